[src/qct_pkg.sv]
// Shared types and constants of the quoted command tokenizer.
package qct_pkg;

  localparam logic [7:0] WS_LOW   = 8'h09;
  localparam logic [7:0] WS_HIGH  = 8'h0D;
  localparam logic [7:0] WS_SPACE = 8'h20;
  localparam logic [7:0] DQUOTE   = 8'h22;
  localparam logic [7:0] SQUOTE   = 8'h27;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_DQUOTE = 2'd1;
  localparam logic [1:0] MODE_SQUOTE = 2'd2;

  localparam logic [7:0] EOC_RESET = 8'h0A;
  localparam logic [7:0] SEP_RESET = 8'h00;

  localparam logic REG_EOC = 1'b0;
  localparam logic REG_SEP = 1'b1;

  localparam int MAX_CHARS   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // One request's worth of output: up to three bytes, the final one may close the command.
  typedef struct packed {
    logic [1:0]                    count;
    logic                          last;
    logic [MAX_CHARS-1:0][7:0]     chars;
  } qct_entry_t;

endpackage

[src/qct_front.sv]
// Front end: accepts input bytes, runs the quote/space state machine, emits output groups.
module qct_front import qct_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic [7:0] eoc_char,
  input  logic [7:0] sep_char,
  input  logic       queue_full,
  output logic       push,
  output qct_entry_t push_entry
);

  logic [1:0] quote_mode;
  logic [1:0] quote_mode_next;
  logic       open_quote_pending;
  logic       open_quote_pending_next;
  logic       collapsing_space;
  logic       collapsing_space_next;

  logic [7:0] c;
  logic [7:0] q;
  logic       q_match;
  logic       is_quote;
  logic       is_white;
  logic [1:0] n;
  logic [MAX_CHARS-1:0][7:0] chars;
  logic       accept;

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    c        = (s_tdata == eoc_char) ? WS_SPACE : s_tdata;
    q        = (quote_mode == MODE_DQUOTE) ? DQUOTE : SQUOTE;
    q_match  = ((quote_mode == MODE_DQUOTE) && (c == DQUOTE)) ||
               ((quote_mode == MODE_SQUOTE) && (c == SQUOTE));
    is_quote = (c == DQUOTE) || (c == SQUOTE);
    is_white = ((c >= WS_LOW) && (c <= WS_HIGH)) || (c == WS_SPACE);

    n                       = 2'd0;
    chars                   = '0;
    quote_mode_next         = quote_mode;
    open_quote_pending_next = open_quote_pending;
    collapsing_space_next   = collapsing_space;

    priority if (open_quote_pending) begin
      open_quote_pending_next = 1'b0;
      collapsing_space_next   = 1'b0;
      if (q_match) begin
        // empty pair passes through
        chars[0]        = q;
        chars[1]        = q;
        n               = 2'd2;
        quote_mode_next = MODE_NONE;
      end else begin
        chars[0] = c;
        n        = 2'd1;
      end
    end else if (quote_mode != MODE_NONE) begin
      if (q_match) begin
        chars[0]              = sep_char;
        n                     = 2'd1;
        quote_mode_next       = MODE_NONE;
        collapsing_space_next = 1'b1;
      end else begin
        chars[0] = c;
        n        = 2'd1;
      end
    end else if (is_quote) begin
      // hold the opening quote until the next byte decides
      quote_mode_next         = (c == DQUOTE) ? MODE_DQUOTE : MODE_SQUOTE;
      open_quote_pending_next = 1'b1;
      collapsing_space_next   = 1'b0;
    end else if (is_white) begin
      if (!collapsing_space) begin
        chars[0] = sep_char;
        n        = 2'd1;
      end
      collapsing_space_next = 1'b1;
    end else begin
      chars[0]              = c;
      n                     = 2'd1;
      collapsing_space_next = 1'b0;
    end

    if (s_tlast) begin
      chars[n]                = eoc_char;
      n                       = n + 2'd1;
      quote_mode_next         = MODE_NONE;
      open_quote_pending_next = 1'b0;
      collapsing_space_next   = 1'b0;
    end

    push_entry.count = n;
    push_entry.last  = s_tlast;
    push_entry.chars = chars;
  end

  assign push = accept && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode         <= MODE_NONE;
      open_quote_pending <= 1'b0;
      collapsing_space   <= 1'b0;
    end else if (accept) begin
      quote_mode         <= quote_mode_next;
      open_quote_pending <= open_quote_pending_next;
      collapsing_space   <= collapsing_space_next;
    end
  end

endmodule

[src/qct_queue.sv]
// Short queue of output groups between the front end and the back end.
module qct_queue import qct_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  qct_entry_t push_entry,
  input  logic       pop,
  output qct_entry_t head,
  output logic       full,
  output logic       empty
);

  qct_entry_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     fill;

  assign full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      unique case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

[src/qct_back.sv]
// Back end: walks each queued group onto the output stream, one byte per cycle while m_tready is high.
module qct_back import qct_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  qct_entry_t head,
  input  logic       empty,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast
);

  qct_entry_t cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       at_end;
  logic       sent;

  assign at_end   = (idx == (cur.count - 2'd1));
  assign sent     = cur_valid && m_tready;
  assign pop      = !empty && (!cur_valid || (sent && at_end));
  assign m_tvalid = cur_valid;
  assign m_tlast  = cur.last && at_end;

  always_comb begin
    unique case (idx)
      2'd0:    m_tdata = cur.chars[0];
      2'd1:    m_tdata = cur.chars[1];
      2'd2:    m_tdata = cur.chars[2];
      default: m_tdata = cur.chars[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (sent) begin
      if (at_end) begin
        cur_valid <= 1'b0;
        idx       <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

[src/quoted_command_tokenizer_top.sv]
// Quoted command tokenizer: one input byte can be taken every cycle while the four-entry
// queue has room; each input byte yields zero to three output bytes, and the output side
// delivers one byte per cycle while m_tready is high, so an item that yields several
// bytes holds the output until all are sent; the sustained rate is one input per cycle
// only while items yield at most one byte. Results are registered in the queue, then in
// the back end. Configuration registers: byte address 0 (end-of-command), 4 (separator).
module quoted_command_tokenizer_top import qct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_char
  input  logic        s_tlast,   // in_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_char
  output logic        m_tlast,   // out_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] end_of_command_char;
  logic [7:0] token_separator_char;
  logic       cfg_write;

  logic       queue_full;
  logic       queue_empty;
  logic       push;
  logic       pop;
  qct_entry_t push_entry;
  qct_entry_t head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_of_command_char  <= EOC_RESET;
      token_separator_char <= SEP_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_EOC: end_of_command_char  <= pwdata[7:0];
        REG_SEP: token_separator_char <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_EOC: prdata = {24'd0, end_of_command_char};
      REG_SEP: prdata = {24'd0, token_separator_char};
      default: prdata = '0;
    endcase
  end

  qct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .eoc_char   (end_of_command_char),
    .sep_char   (token_separator_char),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  qct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (queue_full),
    .empty      (queue_empty)
  );

  qct_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (queue_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

[src/qct_checker.sv]
// Port-level checks of the quoted command tokenizer, bound to the top level.
module qct_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output request dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output request changed while stalled");

  // an accepted closing byte must be followed by a pending output request
  a_last_output: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |-> ##2 m_tvalid)
    else $error("no output after the final input byte");

  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready |=>
      (paddr[2] != $past(paddr[2])) ||
      (prdata == {24'd0, $past(pwdata[7:0])}))
    else $error("register read does not return the written value");

endmodule

bind quoted_command_tokenizer_top qct_checker u_qct_checker (.*);

[test/qct_token_scoreboard.sv]
// Scoreboard for the quoted command tokenizer: predicts the output byte stream and compares it.
module qct_token_scoreboard import qct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_char
  input  logic        s_tlast,   // in_last
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [7:0] out_char
  input  logic        m_tlast,   // out_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          outstanding,
  output int          bytes_checked
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_byte_t;

  out_byte_t  expected_bytes[$];
  logic [7:0] eoc_char;
  logic [7:0] sep_char;
  logic [1:0] in_quote;
  logic       quote_held;
  logic       after_sep;

  function automatic logic is_blank(logic [7:0] c);
    return (c >= WS_LOW && c <= WS_HIGH) || c == WS_SPACE;
  endfunction

  // Bit 8 set means no byte can match.
  function automatic logic [8:0] quote_of(logic [1:0] m);
    case (m)
      MODE_DQUOTE: return {1'b0, DQUOTE};
      MODE_SQUOTE: return {1'b0, SQUOTE};
      default:     return 9'h100;
    endcase
  endfunction

  function automatic void emit(logic [7:0] c, logic l);
    out_byte_t b;
    b.ch   = c;
    b.last = l;
    expected_bytes.push_back(b);
  endfunction

  // Advance the tokenizer state by one request and queue the bytes it yields.
  function automatic void tokenize_byte(logic [7:0] raw, logic l);
    logic [7:0] c;
    logic [8:0] q;
    c = (raw == eoc_char) ? WS_SPACE : raw;
    q = quote_of(in_quote);
    if (quote_held) begin
      quote_held = 1'b0;
      if ({1'b0, c} == q) begin
        emit(q[7:0], 1'b0);
        emit(q[7:0], 1'b0);
        in_quote = MODE_NONE;
      end else begin
        emit(c, 1'b0);
      end
      after_sep = 1'b0;
    end else if (in_quote != MODE_NONE) begin
      if ({1'b0, c} == q) begin
        emit(sep_char, 1'b0);
        in_quote  = MODE_NONE;
        after_sep = 1'b1;
      end else begin
        emit(c, 1'b0);
      end
    end else if (c == DQUOTE || c == SQUOTE) begin
      in_quote   = (c == DQUOTE) ? MODE_DQUOTE : MODE_SQUOTE;
      quote_held = 1'b1;
      after_sep  = 1'b0;
    end else if (is_blank(c)) begin
      if (!after_sep) emit(sep_char, 1'b0);
      after_sep = 1'b1;
    end else begin
      emit(c, 1'b0);
      after_sep = 1'b0;
    end
    if (l) begin
      emit(eoc_char, 1'b1);
      in_quote   = MODE_NONE;
      quote_held = 1'b0;
      after_sep  = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    out_byte_t want;
    if (rst) begin
      eoc_char      = EOC_RESET;
      sep_char      = SEP_RESET;
      in_quote      = MODE_NONE;
      quote_held    = 1'b0;
      after_sep     = 1'b0;
      expected_bytes.delete();
      errors        <= 0;
      bytes_checked <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_EOC) eoc_char = pwdata[7:0];
        else sep_char = pwdata[7:0];
      end
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected output byte %02h last %0b", $time, m_tdata, m_tlast);
          errors <= errors + 1;
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked <= bytes_checked + 1;
          if (m_tdata !== want.ch || m_tlast !== want.last) begin
            $display("%0t: output mismatch, expected char %02h last %0b, got char %02h last %0b",
                     $time, want.ch, want.last, m_tdata, m_tlast);
            errors <= errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) tokenize_byte(s_tdata, s_tlast);
    end
    outstanding <= expected_bytes.size();
  end

endmodule

[test/tb_quoted_command_tokenizer_top.sv]
// Testbench top for the quoted command tokenizer: stimulus, stalls, register writes and verdict.
module tb_quoted_command_tokenizer_top;
  import qct_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 14;
  localparam int NUM_PHASES   = 5;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int outstanding;
  int bytes_checked;
  int idle_cycles   = 0;
  int items_sent    = 0;
  int commands_sent = 0;
  int settings_used = 1;
  int stall_left    = 0;
  bit steady        = 1'b0;

  logic [7:0] cur_eoc = EOC_RESET;
  logic [7:0] cmd_bytes[$];

  quoted_command_tokenizer_top DUT (.*);

  qct_token_scoreboard token_sb (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .outstanding, .bytes_checked
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short holds, now and then a long one.
  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 8'($urandom_range(8'h28, 8'h7E));
    if (r == 7) return cur_eoc;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(0, 6);
    if (r < 5) return WS_LOW + 8'(r);
    if (r == 5) return WS_SPACE;
    return cur_eoc;
  endfunction

  function automatic logic [7:0] quoted_char(logic [7:0] q);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return (q == DQUOTE) ? SQUOTE : DQUOTE;
    if (r == 1) return cur_eoc;
    if (r == 2) return blank_char();
    return word_char();
  endfunction

  // Receiver side: random holds on m_tready unless running steady.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_len() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] c, logic l);
    int gap;
    gap = (!steady && $urandom_range(0, 2) == 0) ? stall_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_command();
    foreach (cmd_bytes[i]) send_byte(cmd_bytes[i], i == cmd_bytes.size() - 1);
    commands_sent++;
  endtask

  // Drop valid, wait for every predicted byte, then let the pipeline drain.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Build one command: words, blank runs, quoted runs, empty pairs and raw noise.
  task automatic gen_command();
    int         parts;
    int         kind;
    int         len;
    logic [7:0] q;
    cmd_bytes.delete();
    parts = $urandom_range(1, 4);
    repeat (parts) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        len = $urandom_range(1, 4);
        repeat (len) cmd_bytes.push_back(word_char());
      end else if (kind <= 5) begin
        len = $urandom_range(1, 3);
        repeat (len) cmd_bytes.push_back(blank_char());
      end else if (kind <= 8) begin
        q = $urandom_range(0, 1) ? DQUOTE : SQUOTE;
        cmd_bytes.push_back(q);
        if (kind == 8) begin
          cmd_bytes.push_back(q);
        end else begin
          len = $urandom_range(0, 4);
          repeat (len) cmd_bytes.push_back(quoted_char(q));
          if ($urandom_range(0, 4) != 0) cmd_bytes.push_back(q);
        end
      end else begin
        len = $urandom_range(1, 3);
        repeat (len) cmd_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    // occasionally end on a lone opening quote
    if ($urandom_range(0, 9) == 0) cmd_bytes.push_back($urandom_range(0, 1) ? DQUOTE : SQUOTE);
  endtask

  initial begin
    logic [7:0] eoc_set[NUM_PHASES];
    logic [7:0] sep_set[NUM_PHASES];
    int         phase_start;
    eoc_set = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), DQUOTE, EOC_RESET};
    sep_set = '{8'hFF, 8'h20, 8'($urandom_range(0, 255)), 8'h0A, SEP_RESET};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // leading blanks, every blank kind, terminator outside and inside quotes, close then word
    cmd_bytes = '{8'h20, 8'h09, 8'h61, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
                  DQUOTE, 8'h78, SQUOTE, 8'h0A, DQUOTE, 8'h62};
    send_command();
    // empty pairs of both kinds, extreme bytes, other quote kept literal inside quotes
    cmd_bytes = '{SQUOTE, SQUOTE, DQUOTE, DQUOTE, 8'h00, 8'hFF,
                  DQUOTE, SQUOTE, 8'h71, DQUOTE};
    send_command();
    // quote held at the very end
    cmd_bytes = '{DQUOTE};
    send_command();
    // quote left open at the end
    cmd_bytes = '{SQUOTE, 8'h7A};
    send_command();
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_EOC, eoc_set[p]);
      write_reg(REG_SEP, sep_set[p]);
      cur_eoc = eoc_set[p];
      settings_used++;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        steady <= (p == 1) || ($urandom_range(0, 5) == 0);
        gen_command();
        send_command();
      end
      settle();
    end

    $display("Sent %0d commands (%0d input bytes) under %0d register settings; %0d bytes checked.",
             commands_sent, items_sent, settings_used, bytes_checked);
    $display("Covered blank runs, terminator bytes, empty and held quotes, open runs, noise.");
    if (errors == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
